// File: rtl/chca_pkg.sv
// Shared types, constants and the microcode table of the canonical Huffman code assigner.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package chca_pkg;

    localparam int NUM_SYMBOLS = 256;
    localparam int MAX_LEN     = 16;
    localparam int IDX_W       = $clog2(NUM_SYMBOLS);
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 9;
    localparam int CODE_W      = 16;
    localparam int CFG_W       = 9;
    localparam int ACC_W       = IDX_W + MAX_LEN;
    localparam int PC_W        = 3;

    typedef enum logic [0:0] {
        REG_SYMBOL_COUNT = 1'b0,
        REG_LSB_FIRST    = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_START,
        COND_NOT_LAST,
        COND_OUT_BUSY,
        COND_ALWAYS
    } cond_t;

    typedef enum logic [PC_W-1:0] {
        STEP_IDLE,
        STEP_READ_SYM,
        STEP_LATCH_LEN,
        STEP_ACCUM,
        STEP_WAIT_OUT,
        STEP_FORM
    } step_t;

    typedef enum logic [0:0] {
        RD_SYM,
        RD_IDX
    } rd_sel_t;

    typedef struct packed {
        logic    in_ready;
        rd_sel_t rd_sel;
        logic    clear_acc;
        logic    latch_len;
        logic    accumulate;
        logic    load_out;
        cond_t   cond;
        step_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic query_start;
        logic last_entry;
        logic out_busy;
    } dp_status_t;

    function automatic ctrl_word_t microcode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{in_ready: 1'b0, rd_sel: RD_IDX, clear_acc: 1'b0, latch_len: 1'b0,
              accumulate: 1'b0, load_out: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:
            begin
                w.in_ready  = 1'b1;
                w.clear_acc = 1'b1;
                w.cond      = COND_NO_START;
                w.target    = STEP_IDLE;
            end
            STEP_READ_SYM:
            begin
                w.rd_sel = RD_SYM;
                w.cond   = COND_NONE;
            end
            STEP_LATCH_LEN:
            begin
                w.latch_len = 1'b1;
                w.cond      = COND_NONE;
            end
            STEP_ACCUM:
            begin
                w.accumulate = 1'b1;
                w.cond       = COND_NOT_LAST;
                w.target     = STEP_ACCUM;
            end
            STEP_WAIT_OUT:
            begin
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_WAIT_OUT;
            end
            STEP_FORM:
            begin
                w.load_out = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/chca_len_ram.sv
// Code length table: one write port and one registered read port.
// Depends on chca_pkg for the depth and the entry width.
`timescale 1ns / 1ps
`default_nettype none

module chca_len_ram
    import chca_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [LEN_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [LEN_W-1:0] rd_data
);

    logic [LEN_W-1:0] mem [NUM_SYMBOLS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/chca_sequencer.sv
// Microcode sequencer: step counter, control word table and conditional jumps.
// Depends on chca_pkg for the control word, the status struct and the table.
`timescale 1ns / 1ps
`default_nettype none

module chca_sequencer
    import chca_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t status,
    output ctrl_word_t      ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take_jump;

    assign ctrl = microcode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NONE:     take_jump = 1'b0;
            COND_NO_START: take_jump = !status.query_start;
            COND_NOT_LAST: take_jump = !status.last_entry;
            COND_OUT_BUSY: take_jump = status.out_busy;
            COND_ALWAYS:   take_jump = 1'b1;
            default:       take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take_jump)
        begin
            pc_next = PC_W'(ctrl.target);
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_W'(STEP_IDLE);
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/chca_datapath.sv
// Datapath: configuration registers, table scan accumulators and the result register.
// Depends on chca_pkg; driven by the control word of chca_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module chca_datapath
    import chca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_word_t        ctrl,
    output dp_status_t             status,
    input  wire logic              cfg_write,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    input  wire logic              kind,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [LEN_W-1:0]  length,
    output logic                   wr_en,
    output logic      [IDX_W-1:0]  wr_addr,
    output logic      [LEN_W-1:0]  wr_data,
    output logic      [IDX_W-1:0]  rd_addr,
    input  wire logic [LEN_W-1:0]  rd_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [SYM_W-1:0]  symbol_out,
    output logic      [CODE_W-1:0] code,
    output logic      [LEN_W-1:0]  bits,
    output logic                   oversubscribed
);

    logic [CNT_W-1:0]   count_reg;
    logic               lsb_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic [ACC_W-1:0]   rank_reg;
    logic [ACC_W-1:0]   kraft_reg;
    logic               out_valid_reg;
    logic [SYM_W-1:0]   sym_out_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [LEN_W-1:0]   bits_reg;
    logic               over_reg;

    logic [CNT_W-1:0]   count_eff;
    logic               take;
    logic [LEN_W-1:0]   weight_shift;
    logic [ACC_W-1:0]   weight;
    logic               before_sym;
    logic [ACC_W-1:0]   rank_shifted;
    logic [ACC_W-1:0]   code_mask;
    logic [MAX_LEN-1:0] code_msb;
    logic [MAX_LEN-1:0] code_rev_full;
    logic [MAX_LEN-1:0] code_rev;
    logic [CODE_W-1:0]  code_final;

    assign count_eff = (count_reg > CNT_W'(NUM_SYMBOLS)) ? CNT_W'(NUM_SYMBOLS) : count_reg;
    assign take      = in_valid && ctrl.in_ready;

    assign status.query_start = take && (kind == KIND_QUERY)
                                && ({1'b0, symbol} < count_eff);
    assign status.last_entry  = (pidx_reg == IDX_W'(count_eff - CNT_W'(1)));
    assign status.out_busy    = out_valid_reg && out_stall;

    always_comb
    begin
        wr_en   = take && (kind == KIND_LOAD);
        wr_addr = IDX_W'(symbol);
        if (length == '0)
        begin
            wr_data = LEN_W'(1);
        end
        else if (length > LEN_W'(MAX_LEN))
        begin
            wr_data = LEN_W'(MAX_LEN);
        end
        else
        begin
            wr_data = length;
        end
    end

    assign rd_addr = (ctrl.rd_sel == RD_SYM) ? IDX_W'(sym_reg) : idx_reg;

    // Weights are scaled to the longest allowed length; ranks scale back exactly.
    assign weight_shift = LEN_W'(MAX_LEN) - rd_data;
    assign weight       = ACC_W'(1) << weight_shift;
    assign before_sym   = (rd_data < len_reg)
                          || ((rd_data == len_reg) && (SYM_W'(pidx_reg) < sym_reg));

    assign rank_shifted = rank_reg >> (LEN_W'(MAX_LEN) - len_reg);
    assign code_mask    = (ACC_W'(1) << len_reg) - ACC_W'(1);
    assign code_msb     = MAX_LEN'(rank_shifted & code_mask);

    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            code_rev_full[i] = code_msb[MAX_LEN-1-i];
        end
    end

    assign code_rev   = code_rev_full >> (LEN_W'(MAX_LEN) - len_reg);
    assign code_final = lsb_reg ? CODE_W'(code_rev) : CODE_W'(code_msb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(NUM_SYMBOLS);
            lsb_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYMBOL_COUNT: count_reg <= CNT_W'(cfg_data);
                REG_LSB_FIRST:    lsb_reg   <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sym_reg <= symbol;
        end
        if (ctrl.latch_len)
        begin
            len_reg <= rd_data;
        end
        if (ctrl.clear_acc)
        begin
            idx_reg   <= '0;
            pidx_reg  <= '0;
            rank_reg  <= '0;
            kraft_reg <= '0;
        end
        else if (ctrl.latch_len || ctrl.accumulate)
        begin
            idx_reg  <= idx_reg + IDX_W'(1);
            pidx_reg <= idx_reg;
        end
        if (ctrl.accumulate)
        begin
            kraft_reg <= kraft_reg + weight;
            if (before_sym)
            begin
                rank_reg <= rank_reg + weight;
            end
        end
        if (ctrl.load_out)
        begin
            sym_out_reg <= sym_reg;
            code_reg    <= code_final;
            bits_reg    <= len_reg;
            over_reg    <= (kraft_reg > (ACC_W'(1) << MAX_LEN));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign symbol_out     = sym_out_reg;
    assign code           = code_reg;
    assign bits           = bits_reg;
    assign oversubscribed = over_reg;

endmodule

`default_nettype wire

// File: rtl/canonical_huffman_code_assigner_unit.sv
// Canonical Huffman code assigner: a microcode sequencer, a datapath and the length table.
// Top level of the block; depends on chca_pkg, chca_sequencer, chca_datapath, chca_len_ram.
//
// Usage: requests arrive on in_valid/in_stall with kind, symbol and length. A load request
// writes one symbol's code length (clamped to 1..16) and gives no result. A query request
// for a symbol below symbol_count gives one result on out_valid/out_stall: the canonical
// code, its length and the oversubscription flag. A query at or above the count is dropped.
// The user must see that configuration is written through cfg_write, cfg_index and cfg_data
// only while the block idles; the block itself does not enforce it. A load leaves the block
// idle and ready for the next request. An accepted query steps through READ_SYM, LATCH_LEN,
// ACCUM, WAIT_OUT and FORM; the length table has one read port, and the sequencer reads
// every entry in use once to add up the rank and the Kraft sum. No further request is taken
// until the query's result is registered.
// Reset clears the step counter, the result valid flag and the configuration registers
// (symbol_count 256, MSB-first order); the table holds no defined value until loaded.
// A stalled result stays in the output register; a new request is still taken meanwhile,
// and a following query waits before its final step until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module canonical_huffman_code_assigner_unit
    import chca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              kind,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [LEN_W-1:0]  length,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [SYM_W-1:0]  symbol_out,
    output logic      [CODE_W-1:0] code,
    output logic      [LEN_W-1:0]  bits,
    output logic                   oversubscribed
);

    ctrl_word_t       ctrl;
    dp_status_t       status;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [LEN_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [LEN_W-1:0] rd_data;

    assign in_stall = !ctrl.in_ready;

    chca_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    chca_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .kind           (kind),
        .symbol         (symbol),
        .length         (length),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .symbol_out     (symbol_out),
        .code           (code),
        .bits           (bits),
        .oversubscribed (oversubscribed)
    );

    chca_len_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// File: rtl/chca_checker.sv
// Port-level checker for the canonical Huffman code assigner, bound to the top level.
// Depends on chca_pkg for field widths and the request kind codes.
`timescale 1ns / 1ps
`default_nettype none

module chca_port_checker
    import chca_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             kind,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [SYM_W-1:0] symbol_out
);

    // A result waiting on a stalled receiver is not withdrawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol_out))
        else $error("result withdrawn or changed while stalled");

    // A new result is only formed while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result formed while requests were being taken");

    // A load request never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_LOAD) |=> !$rose(out_valid))
        else $error("load request produced a result");

endmodule

bind canonical_huffman_code_assigner_unit chca_port_checker u_chca_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol_out (symbol_out)
);

`default_nettype wire

// File: tb/sv/chca_checker.sv
// Result checker for the canonical Huffman code assigner: watches the configuration port and
// the request and result channels, predicts every query result and compares it field by field.
// Depends on chca_pkg for widths, request kinds and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module chca_checker
    import chca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic              kind,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [LEN_W-1:0]  length,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [SYM_W-1:0]  symbol_out,
    input  wire logic [CODE_W-1:0] code,
    input  wire logic [LEN_W-1:0]  bits,
    input  wire logic              oversubscribed,
    output int                     mismatch_count,
    output int                     outstanding
);

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  bits;
        logic              over;
    } code_entry_t;

    logic [LEN_W-1:0] len_table [NUM_SYMBOLS];
    logic [CNT_W-1:0] count_reg;
    logic             lsb_reg;
    code_entry_t      code_q [$];
    int               errs;

    function automatic int active_count();
        return (count_reg > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(count_reg);
    endfunction

    function automatic code_entry_t predict_codeword(input logic [SYM_W-1:0] sym);
        code_entry_t      r;
        int               eff;
        int               i;
        int               mx;
        int               b;
        int               l;
        longint           rank;
        longint           kraft;
        longint           w;
        logic [31:0]      cw;
        logic [CODE_W-1:0] word;
        eff = active_count();
        b = len_table[sym];
        mx = 0;
        for (i = 0; i < eff; i++)
        begin
            l = len_table[i];
            if (l > mx)
                mx = l;
        end
        rank = 0;
        kraft = 0;
        for (i = 0; i < eff; i++)
        begin
            l = len_table[i];
            w = longint'(1) << (mx - l);
            kraft += w;
            if (l < b || (l == b && i < sym))
                rank += w;
        end
        cw = 32'((rank >> (mx - b)) & ((longint'(1) << b) - 1));
        word = cw[CODE_W-1:0];
        if (lsb_reg)
        begin
            word = '0;
            for (i = 0; i < b; i++)
                word[b - 1 - i] = cw[i];
        end
        r.symbol = sym;
        r.code   = word;
        r.bits   = b[LEN_W-1:0];
        r.over   = (kraft > (longint'(1) << mx));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        code_entry_t e;
        int          l;
        if (!rst_n)
        begin
            count_reg = CNT_W'(NUM_SYMBOLS);
            lsb_reg   = 1'b0;
            code_q.delete();
            errs = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (code_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected result for symbol %0d", $realtime, symbol_out);
                end
                else
                begin
                    e = code_q.pop_front();
                    if (symbol_out !== e.symbol || code !== e.code || bits !== e.bits
                        || oversubscribed !== e.over)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: expected %0d %h %0d %0b, actual %0d %h %0d %0b",
                                     $realtime, e.symbol, e.code, e.bits, e.over,
                                     symbol_out, code, bits, oversubscribed);
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_SYMBOL_COUNT)
                    count_reg = cfg_data[CNT_W-1:0];
                else if (cfg_index == REG_LSB_FIRST)
                    lsb_reg = cfg_data[0];
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_LOAD)
                begin
                    l = length;
                    if (l < 1)
                        l = 1;
                    if (l > MAX_LEN)
                        l = MAX_LEN;
                    len_table[symbol] = l[LEN_W-1:0];
                end
                else if (symbol < active_count())
                    code_q = {code_q, predict_codeword(symbol)};
            end
            mismatch_count <= errs;
            outstanding    <= code_q.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Top of the canonical Huffman code assigner testbench: clock, reset, configuration writes,
// load and query requests under varying idle and stall pressure, and the final verdict.
// Depends on chca_pkg, canonical_huffman_code_assigner_unit and chca_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import chca_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 110;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_write = 1'b0;
    logic [0:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              kind      = 1'b0;
    logic [SYM_W-1:0]  symbol    = '0;
    logic [LEN_W-1:0]  length    = 5'd1;
    logic              out_stall = 1'b0;
    wire logic         in_stall;
    wire logic         out_valid;
    wire logic [SYM_W-1:0]  symbol_out;
    wire logic [CODE_W-1:0] code;
    wire logic [LEN_W-1:0]  bits;
    wire logic         oversubscribed;
    int                mismatch_count;
    int                outstanding;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cur_count = NUM_SYMBOLS;

    always #5 clk = ~clk;

    canonical_huffman_code_assigner_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .symbol(symbol), .length(length),
        .out_valid(out_valid), .out_stall(out_stall),
        .symbol_out(symbol_out), .code(code), .bits(bits), .oversubscribed(oversubscribed)
    );

    chca_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .symbol(symbol), .length(length),
        .out_valid(out_valid), .out_stall(out_stall),
        .symbol_out(symbol_out), .code(code), .bits(bits), .oversubscribed(oversubscribed),
        .mismatch_count(mismatch_count), .outstanding(outstanding)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(1, 100) <= stall_pct);

    task automatic send_request(input kind_t k, input logic [SYM_W-1:0] s,
                                input logic [LEN_W-1:0] l);
        while ($urandom_range(1, 100) <= idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        symbol   <= s;
        length   <= l;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    task automatic query(input logic [SYM_W-1:0] s);
        send_request(KIND_QUERY, s, LEN_W'($urandom_range(0, 31)));
    endtask

    task automatic load(input logic [SYM_W-1:0] s, input logic [LEN_W-1:0] l);
        send_request(KIND_LOAD, s, l);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int count, input logic lsb);
        drain();
        write_reg(REG_SYMBOL_COUNT, CFG_W'(count));
        write_reg(REG_LSB_FIRST, CFG_W'(lsb));
        cur_count = count;
    endtask

    // Builds a complete prefix code by splitting random leaves (a lone symbol gets a random length),
    // then shuffles it over the symbols in use; now and then one length is spoiled afterwards.
    task automatic load_code_set(input int n, output int sent);
        int lens [NUM_SYMBOLS];
        int leaves;
        int pick;
        int j;
        int tmp;
        sent = 0;
        if (n > NUM_SYMBOLS)
            n = NUM_SYMBOLS;
        if (n < 1)
            return;
        lens[0] = 0;
        leaves = 1;
        while (leaves < n)
        begin
            pick = $urandom_range(0, leaves - 1);
            if (lens[pick] < MAX_LEN)
            begin
                lens[pick]++;
                lens[leaves] = lens[pick];
                leaves++;
            end
        end
        if (n == 1)
            lens[0] = $urandom_range(1, MAX_LEN);
        for (j = n - 1; j > 0; j--)
        begin
            pick = $urandom_range(0, j);
            tmp = lens[j];
            lens[j] = lens[pick];
            lens[pick] = tmp;
        end
        if ($urandom_range(0, 4) == 0)
            lens[$urandom_range(0, n - 1)] = $urandom_range(1, MAX_LEN);
        for (j = 0; j < n; j++)
            load(SYM_W'(j), LEN_W'(lens[j]));
        sent = n;
    endtask

    initial
    begin
        int i;
        int r;
        int eff;
        int items;
        int phase;
        int nreq;
        int sent;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_SYMBOLS; i++)
            load(SYM_W'(i), LEN_W'($urandom_range(0, 31)));

        query(8'd0);
        query(8'd255);
        set_config(1, 1'b0);
        load(8'd0, 5'd0);
        query(8'd0);
        query(8'd1);
        query(8'd255);
        set_config(2, 1'b0);
        load(8'd0, 5'd1);
        load(8'd1, 5'd1);
        query(8'd0);
        query(8'd1);
        load(8'd1, 5'd31);
        query(8'd1);
        query(8'd0);
        set_config(2, 1'b1);
        query(8'd1);
        set_config(3, 1'b1);
        load(8'd1, 5'd2);
        load(8'd2, 5'd2);
        query(8'd2);
        query(8'd1);
        set_config(0, 1'b0);
        query(8'd0);
        set_config(511, 1'b1);
        load(8'd255, 5'd16);
        query(8'd255);
        query(8'd128);
        set_config(NUM_SYMBOLS, 1'b0);
        query(8'd17);

        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                set_config($urandom_range(1, 24), 1'($urandom_range(0, 1)));
            else if (r < 88)
                set_config($urandom_range(25, 80), 1'($urandom_range(0, 1)));
            else if (r < 95)
                set_config(NUM_SYMBOLS, 1'($urandom_range(0, 1)));
            else if (r < 98)
                set_config($urandom_range(257, 511), 1'($urandom_range(0, 1)));
            else
                set_config(0, 1'($urandom_range(0, 1)));
            eff = (cur_count > NUM_SYMBOLS) ? NUM_SYMBOLS : cur_count;
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 81; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            phase++;
            if (eff <= 80 && $urandom_range(0, 99) < 80)
            begin
                load_code_set(eff, sent);
                items += sent;
            end
            nreq = $urandom_range(8, 24);
            for (i = 0; i < nreq; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 80 && eff > 0)
                    query(SYM_W'($urandom_range(0, eff - 1)));
                else if (r < 90)
                    query(SYM_W'($urandom_range(0, 255)));
                else
                    load(SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 31)));
            end
            items += nreq;
        end

        drain();
        if (mismatch_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
